FILE: design/ppl_pkg.sv
// ----------------------------------------------------------------------------
// ppl_pkg
// Shared types, codes and default sizes for the page pool allocator.
// ----------------------------------------------------------------------------
package ppl_pkg;

  localparam int MAX_PAGES_DEF  = 256;
  localparam int MAX_EVICT_DEF  = 16;
  localparam int STAMP_BITS_DEF = 32;

  localparam logic [2:0] FUNC_ALLOC      = 3'd0;
  localparam logic [2:0] FUNC_RELEASE    = 3'd1;
  localparam logic [2:0] FUNC_TOUCH      = 3'd2;
  localparam logic [2:0] FUNC_EVICT      = 3'd3;
  localparam logic [2:0] FUNC_COMPRESS   = 3'd4;
  localparam logic [2:0] FUNC_DECOMPRESS = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] page_id;
    logic [4:0] evict_limit;
  } cmd_t;

  typedef struct packed {
    logic [7:0] page_out;
    logic [1:0] status;
    logic [4:0] evicted_so_far;
    logic       final_result;
  } res_t;

endpackage

FILE: design/ppl_ram.sv
// ----------------------------------------------------------------------------
// ppl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ppl_scan.sv
// ----------------------------------------------------------------------------
// ppl_scan
// Tracks the oldest evictable page seen during one pass over the page store.
// ----------------------------------------------------------------------------
module ppl_scan #(
  parameter int PW         = 8,
  parameter int STAMP_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  valid,
  input  logic [PW-1:0]         idx,
  input  logic                  in_use,
  input  logic                  resident,
  input  logic                  comp,
  input  logic [STAMP_BITS-1:0] stamp,
  output logic                  found,
  output logic [PW-1:0]         best_idx,
  output logic                  best_comp,
  output logic [STAMP_BITS-1:0] best_stamp
);

  logic take;

  assign take = valid && !in_use && resident && (!found || (stamp < best_stamp));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx   <= idx;
      best_comp  <= comp;
      best_stamp <= stamp;
    end
  end

endmodule

FILE: design/page_pool_lru_allocator.sv
// ----------------------------------------------------------------------------
// page_pool_lru_allocator
// Page pool with LIFO free stack, access stamps and oldest-first eviction.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each result is shown
// for one cycle with done high and must be captured then. Allocate from an
// empty stack, and requests answered without a memory read, are answered
// straight from S_IDLE; requests that read the page or stack memory first go
// through S_APOP or S_MOD. Evict runs one full pass over the page memory per
// evicted page through its single read port; S_FLUSH gives the last result
// when the limit is reached; a pass that finds nothing ends the request.
module page_pool_lru_allocator
  import ppl_pkg::*;
#(
  parameter int MAX_PAGES  = ppl_pkg::MAX_PAGES_DEF,
  parameter int MAX_EVICT  = ppl_pkg::MAX_EVICT_DEF,
  parameter int STAMP_BITS = ppl_pkg::STAMP_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ppl_pkg::cmd_t cmd,
  output logic          done,
  output ppl_pkg::res_t result
);

  localparam int PW   = $clog2(MAX_PAGES);
  localparam int SW   = $clog2(MAX_PAGES + 1);
  localparam int CMPW = (SW > 8) ? SW : 8;
  localparam int CW   = $clog2(MAX_EVICT + 1);
  localparam int EW   = (CW > 5) ? CW : 5;
  localparam int DW   = STAMP_BITS + 3;
  localparam int B_IN = STAMP_BITS + 2;
  localparam int B_RS = STAMP_BITS + 1;
  localparam int B_CP = STAMP_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOD   = 5'b00010,
    S_APOP  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t                state;
  cmd_t                  cmd_q;
  logic [SW-1:0]         free_count;
  logic [SW-1:0]         pool_size;
  logic [STAMP_BITS-1:0] stamp_counter;
  logic [EW-1:0]         lim_q;
  logic [EW-1:0]         ev_count;
  logic [SW-1:0]         scan_addr;
  logic                  rd_pend;
  logic [PW-1:0]         rd_idx;
  logic                  pend_valid;
  logic [PW-1:0]         pend_idx;
  logic [EW-1:0]         pend_cnt;
  logic                  done_next;
  res_t                  result_next;

  logic                  page_we;
  logic [PW-1:0]         page_waddr;
  logic [DW-1:0]         page_wdata;
  logic [PW-1:0]         page_raddr;
  logic [DW-1:0]         page_rdata;
  logic                  stk_we;
  logic [PW-1:0]         stk_waddr;
  logic [PW-1:0]         stk_wdata;
  logic [PW-1:0]         stk_raddr;
  logic [PW-1:0]         stk_rdata;

  logic                  accept;
  logic                  in_pool;
  logic [EW-1:0]         lim_sat;
  logic [PW-1:0]         q_idx;
  logic                  issue;
  logic                  round_done;
  logic                  scan_clear;
  logic                  found;
  logic [PW-1:0]         best_idx;
  logic                  best_comp;
  logic [STAMP_BITS-1:0] best_stamp;
  logic [1:0]            mod_status;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign in_pool    = CMPW'(cmd.page_id) < CMPW'(pool_size);
  assign lim_sat    = (EW'(cmd.evict_limit) > EW'(MAX_EVICT)) ? EW'(MAX_EVICT)
                                                              : EW'(cmd.evict_limit);
  assign q_idx      = PW'(cmd_q.page_id);
  assign issue      = (state == S_SCAN) && (scan_addr < pool_size);
  assign round_done = (state == S_SCAN) && !issue && !rd_pend;
  assign scan_clear = (accept && cmd.func == FUNC_EVICT) || (round_done && found);
  assign stk_raddr  = PW'(free_count - 1'b1);
  assign page_raddr = (state == S_SCAN) ? PW'(scan_addr) : PW'(cmd.page_id);

  ppl_ram #(.WIDTH(DW), .DEPTH(MAX_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (page_wdata),
    .raddr (page_raddr),
    .rdata (page_rdata)
  );

  ppl_ram #(.WIDTH(PW), .DEPTH(MAX_PAGES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  ppl_scan #(.PW(PW), .STAMP_BITS(STAMP_BITS)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (scan_clear),
    .valid      (rd_pend),
    .idx        (rd_idx),
    .in_use     (page_rdata[B_IN]),
    .resident   (page_rdata[B_RS]),
    .comp       (page_rdata[B_CP]),
    .stamp      (page_rdata[STAMP_BITS-1:0]),
    .found      (found),
    .best_idx   (best_idx),
    .best_comp  (best_comp),
    .best_stamp (best_stamp)
  );

  always_comb begin
    mod_status = ST_OK;
    unique case (cmd_q.func)
      FUNC_RELEASE: begin
        if (!page_rdata[B_IN] || free_count >= SW'(MAX_PAGES)) begin
          mod_status = ST_NONE;
        end
      end
      FUNC_COMPRESS: begin
        if (page_rdata[B_CP]) begin
          mod_status = ST_NONE;
        end
      end
      FUNC_DECOMPRESS: begin
        if (!page_rdata[B_CP]) begin
          mod_status = ST_NONE;
        end
      end
      default: mod_status = ST_OK;
    endcase
  end

  always_comb begin
    page_we    = 1'b0;
    page_waddr = PW'(pool_size);
    page_wdata = {3'b110, stamp_counter};
    stk_we     = 1'b0;
    stk_waddr  = PW'(free_count);
    stk_wdata  = q_idx;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd.func == FUNC_ALLOC && free_count == '0 &&
            pool_size < SW'(MAX_PAGES)) begin
          page_we = 1'b1;
        end
      end
      S_APOP: begin
        page_we    = 1'b1;
        page_waddr = stk_rdata;
      end
      S_MOD: begin
        page_waddr = q_idx;
        page_wdata = page_rdata;
        if (mod_status == ST_OK) begin
          page_we = 1'b1;
          unique case (cmd_q.func)
            FUNC_RELEASE: begin
              page_wdata[B_IN] = 1'b0;
              stk_we           = 1'b1;
            end
            FUNC_TOUCH:      page_wdata[STAMP_BITS-1:0] = stamp_counter;
            FUNC_COMPRESS:   page_wdata[B_CP] = 1'b1;
            FUNC_DECOMPRESS: page_wdata[B_CP] = 1'b0;
            default:         page_we = 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        page_waddr = best_idx;
        page_wdata = {2'b00, best_comp, best_stamp};
        page_we    = round_done && found;
      end
      S_FLUSH: page_we = 1'b0;
      default: page_we = 1'b0;
    endcase
  end

  always_comb begin
    done_next   = 1'b0;
    result_next = result;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          result_next = '{page_out: cmd.page_id, status: ST_NONE,
                          evicted_so_far: 5'd0, final_result: 1'b1};
          unique case (cmd.func)
            FUNC_ALLOC: begin
              if (free_count == '0) begin
                done_next = 1'b1;
                if (pool_size < SW'(MAX_PAGES)) begin
                  result_next.page_out = 8'(pool_size);
                  result_next.status   = ST_OK;
                end else begin
                  result_next.page_out = 8'd0;
                  result_next.status   = ST_FULL;
                end
              end
            end
            FUNC_EVICT: begin
              if (lim_sat == '0) begin
                result_next.page_out = 8'd0;
                done_next            = 1'b1;
              end
            end
            FUNC_RELEASE, FUNC_TOUCH, FUNC_COMPRESS, FUNC_DECOMPRESS: begin
              if (!in_pool) begin
                result_next.status = ST_RANGE;
                done_next          = 1'b1;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      S_APOP: begin
        result_next.page_out = 8'(stk_rdata);
        result_next.status   = ST_OK;
        done_next            = 1'b1;
      end
      S_MOD: begin
        result_next.status = mod_status;
        done_next          = 1'b1;
      end
      S_SCAN: begin
        if (round_done) begin
          if (pend_valid) begin
            result_next = '{page_out: 8'(pend_idx), status: ST_OK,
                            evicted_so_far: 5'(pend_cnt), final_result: !found};
            done_next   = 1'b1;
          end else if (!found) begin
            result_next = '{page_out: 8'd0, status: ST_NONE,
                            evicted_so_far: 5'd0, final_result: 1'b1};
            done_next   = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        result_next = '{page_out: 8'(pend_idx), status: ST_OK,
                        evicted_so_far: 5'(pend_cnt), final_result: 1'b1};
        done_next   = 1'b1;
      end
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      free_count    <= '0;
      pool_size     <= '0;
      stamp_counter <= '0;
      done          <= 1'b0;
      rd_pend       <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      done   <= done_next;
      result <= result_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= cmd;
            unique case (cmd.func)
              FUNC_ALLOC: begin
                if (free_count != '0) begin
                  free_count <= free_count - 1'b1;
                  state      <= S_APOP;
                end else if (pool_size < SW'(MAX_PAGES)) begin
                  pool_size     <= pool_size + 1'b1;
                  stamp_counter <= stamp_counter + 1'b1;
                end
              end
              FUNC_EVICT: begin
                lim_q      <= lim_sat;
                ev_count   <= '0;
                pend_valid <= 1'b0;
                scan_addr  <= '0;
                rd_pend    <= 1'b0;
                if (lim_sat != '0) begin
                  state <= S_SCAN;
                end
              end
              FUNC_RELEASE, FUNC_TOUCH, FUNC_COMPRESS, FUNC_DECOMPRESS: begin
                if (in_pool) begin
                  state <= S_MOD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_APOP: begin
          stamp_counter <= stamp_counter + 1'b1;
          state         <= S_IDLE;
        end
        S_MOD: begin
          if (mod_status == ST_OK && cmd_q.func == FUNC_RELEASE) begin
            free_count <= free_count + 1'b1;
          end
          if (mod_status == ST_OK && cmd_q.func == FUNC_TOUCH) begin
            stamp_counter <= stamp_counter + 1'b1;
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          rd_pend <= issue;
          rd_idx  <= PW'(scan_addr);
          if (issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (round_done) begin
            if (found) begin
              pend_valid <= 1'b1;
              pend_idx   <= best_idx;
              pend_cnt   <= ev_count + 1'b1;
              ev_count   <= ev_count + 1'b1;
              scan_addr  <= '0;
              if (ev_count + 1'b1 == lim_q) begin
                state <= S_FLUSH;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_free_le_pool: assert property (@(posedge clk) disable iff (rst)
    free_count <= pool_size) else $error("free stack deeper than pool");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    pool_size <= SW'(MAX_PAGES)) else $error("pool beyond bound");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    done && result.final_result |-> !busy) else $error("busy after last result");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    done && !result.final_result |-> busy) else $error("idle before last result");

  a_count_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.evicted_so_far != 5'd0 |-> result.status == ST_OK)
    else $error("eviction count on failed result");

endmodule
